// ===== rtl/core/prs_pkg.sv =====
package prs_pkg;

	// number of round keys held in the key store
	localparam int NUM_ROUND_KEYS = 32;
	localparam int KEY_AW = $clog2(NUM_ROUND_KEYS);

	// field widths
	localparam int BLOCK_W = 64;
	localparam int ROUND_W = 5;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDE_KEY_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 2'd2;

	// round command codes
	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	// key store read request, issued when the first stage loads
	typedef struct packed {
		logic               en;
		logic [ROUND_W-1:0] idx_cur;
		logic [ROUND_W-1:0] idx_next;
	} key_rd_req_t;

	// forward sbox
	function automatic logic [3:0] sbox_fwd(input logic [3:0] n);
		logic [3:0] r;
		unique case (n)
			4'h0: r = 4'hc;
			4'h1: r = 4'h5;
			4'h2: r = 4'h6;
			4'h3: r = 4'hb;
			4'h4: r = 4'h9;
			4'h5: r = 4'h0;
			4'h6: r = 4'ha;
			4'h7: r = 4'hd;
			4'h8: r = 4'h3;
			4'h9: r = 4'he;
			4'ha: r = 4'hf;
			4'hb: r = 4'h8;
			4'hc: r = 4'h4;
			4'hd: r = 4'h7;
			4'he: r = 4'h1;
			default: r = 4'h2;
		endcase
		return r;
	endfunction

	// inverse sbox
	function automatic logic [3:0] sbox_rev(input logic [3:0] n);
		logic [3:0] r;
		unique case (n)
			4'h0: r = 4'h5;
			4'h1: r = 4'he;
			4'h2: r = 4'hf;
			4'h3: r = 4'h8;
			4'h4: r = 4'hc;
			4'h5: r = 4'h1;
			4'h6: r = 4'h2;
			4'h7: r = 4'hd;
			4'h8: r = 4'hb;
			4'h9: r = 4'h4;
			4'ha: r = 4'h6;
			4'hb: r = 4'h3;
			4'hc: r = 4'h0;
			4'hd: r = 4'h7;
			4'he: r = 4'h9;
			default: r = 4'ha;
		endcase
		return r;
	endfunction

	// sixteen parallel sbox lookups
	function automatic logic [BLOCK_W-1:0] sbox_word(input logic [BLOCK_W-1:0] d,
		input logic inv);
		logic [BLOCK_W-1:0] r;
		for (int i = 0; i < BLOCK_W / 4; i++) begin
			r[4*i +: 4] = inv ? sbox_rev(d[4*i +: 4]) : sbox_fwd(d[4*i +: 4]);
		end
		return r;
	endfunction

	// bit permutation, pure wiring
	function automatic logic [BLOCK_W-1:0] perm_bits(input logic [BLOCK_W-1:0] d,
		input logic inv);
		logic [BLOCK_W-1:0] r;
		for (int i = 0; i < BLOCK_W; i++) begin
			if (inv) begin
				r[4 * (i % 16) + i / 16] = d[i];
			end else begin
				r[16 * (i % 4) + i / 4] = d[i];
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/prs_key_sched.sv =====
module prs_key_sched import prs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BLOCK_W-1:0]   cfg_data,
	input  key_rd_req_t          rd_req,
	output logic                 busy,
	output logic [BLOCK_W-1:0]   key_cur,
	output logic [BLOCK_W-1:0]   key_next
);

	localparam logic [KEY_AW-1:0] LAST_IDX = KEY_AW'(NUM_ROUND_KEYS - 1);

	logic               wide_q;
	logic [BLOCK_W-1:0] key_upper_q;
	logic [BLOCK_W-1:0] key_lower_q;
	logic               busy_q;
	logic [KEY_AW-1:0]  cnt_q;
	logic [BLOCK_W-1:0] hi_q;
	logic [BLOCK_W-1:0] lo_q;
	logic [BLOCK_W-1:0] mem [NUM_ROUND_KEYS];
	logic [BLOCK_W-1:0] rd_cur_q;
	logic [BLOCK_W-1:0] rd_next_q;
	logic               cur_ok_q;
	logic               next_ok_q;

	logic               cfg_hit;
	logic [BLOCK_W-1:0] base_hi;
	logic [BLOCK_W-1:0] cur_hi;
	logic [BLOCK_W-1:0] cur_lo;
	logic [BLOCK_W-1:0] nxt_hi;
	logic [BLOCK_W-1:0] nxt_lo;
	logic [BLOCK_W-1:0] rh;
	logic [BLOCK_W-1:0] rl;
	logic [BLOCK_W-1:0] store_val;
	logic [ROUND_W-1:0] rc;

	// a write to a known register restarts the expansion
	assign cfg_hit = cfg_we && (cfg_index == REG_WIDE_KEY_MODE ||
		cfg_index == REG_KEY_UPPER || cfg_index == REG_KEY_LOWER);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b0;
			key_upper_q <= '0;
			key_lower_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDE_KEY_MODE: wide_q <= cfg_data[0];
				REG_KEY_UPPER: key_upper_q <= cfg_data;
				REG_KEY_LOWER: key_lower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// current key: first step starts from the cipher key
	always_comb begin
		base_hi = wide_q ? key_upper_q : {48'b0, key_upper_q[15:0]};
		cur_hi = (cnt_q == '0) ? base_hi : hi_q;
		cur_lo = (cnt_q == '0) ? key_lower_q : lo_q;
		rc = ROUND_W'(cnt_q) + ROUND_W'(1);
	end

	// one schedule update per cycle while the expansion runs
	always_comb begin
		if (!wide_q) begin
			rh = {48'b0, cur_lo[18:3]};
			rl = {cur_lo[2:0], cur_hi[15:0], cur_lo[63:19]};
			rh[15:12] = sbox_fwd(rh[15:12]);
			rl[19:15] = rl[19:15] ^ rc;
			store_val = {cur_hi[15:0], cur_lo[63:16]};
		end else begin
			rh = {cur_hi[2:0], cur_lo[63:3]};
			rl = {cur_lo[2:0], cur_hi[63:3]};
			rh[63:60] = sbox_fwd(rh[63:60]);
			rh[59:56] = sbox_fwd(rh[59:56]);
			rh[2:0] = rh[2:0] ^ rc[4:2];
			rl[63:62] = rl[63:62] ^ rc[1:0];
			store_val = cur_hi;
		end
		nxt_hi = rh;
		nxt_lo = rl;
	end

	// expansion sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (cfg_hit) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == LAST_IDX) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + KEY_AW'(1);
			end
		end
	end

	// running key
	always_ff @(posedge clk) begin
		if (busy_q) begin
			hi_q <= nxt_hi;
			lo_q <= nxt_lo;
		end
	end

	// key store write
	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[cnt_q] <= store_val;
		end
	end

	// key store reads, two ports
	always_ff @(posedge clk) begin
		if (rd_req.en) begin
			rd_cur_q <= mem[rd_req.idx_cur[KEY_AW-1:0]];
			rd_next_q <= mem[rd_req.idx_next[KEY_AW-1:0]];
			cur_ok_q <= {1'b0, rd_req.idx_cur} < (ROUND_W + 1)'(NUM_ROUND_KEYS);
			next_ok_q <= {1'b0, rd_req.idx_next} < (ROUND_W + 1)'(NUM_ROUND_KEYS);
		end
	end

	// an index past the store reads as zero
	assign key_cur = cur_ok_q ? rd_cur_q : '0;
	assign key_next = next_ok_q ? rd_next_q : '0;
	assign busy = busy_q;

endmodule

// ===== rtl/core/prs_round.sv =====
module prs_round import prs_pkg::*; (
	input  logic               command,
	input  logic               final_round,
	input  logic [BLOCK_W-1:0] block_in,
	input  logic [BLOCK_W-1:0] key_cur,
	input  logic [BLOCK_W-1:0] key_next,
	output logic [BLOCK_W-1:0] block_out
);

	logic [BLOCK_W-1:0] enc;
	logic [BLOCK_W-1:0] dec;

	// encrypt: add key, sbox, permute, optional whitening
	always_comb begin
		enc = perm_bits(sbox_word(block_in ^ key_cur, 1'b0), 1'b0);
		if (final_round) begin
			enc = enc ^ key_next;
		end
	end

	// decrypt: the same steps undone in reverse
	always_comb begin
		dec = final_round ? (block_in ^ key_next) : block_in;
		dec = sbox_word(perm_bits(dec, 1'b1), 1'b1) ^ key_cur;
	end

	assign block_out = (command == CMD_DECRYPT) ? dec : enc;

endmodule

// ===== rtl/core/lightweight_cipher_round.sv =====
// One round of the PRESENT 64-bit block cipher, encrypt or decrypt, 80- or
// 128-bit key.
// Configuration: cfg_we with cfg_index and cfg_data writes wide_key_mode (0),
// key_upper (1) or key_lower (2); the user must write only while the block is
// idle, which the block does not enforce. Each such register write starts a
// key expansion, one round key per cycle into the key store; in_stall stays
// high until it is done. Reset: registers clear to an all-zero 80-bit key and
// the same expansion runs, so in_stall is also high after reset until done.
// Input channel: command, round_number, final_round, block_in, transferred
// when in_valid is high and in_stall low. Output channel: block_out,
// transferred when out_valid is high and out_stall low.
// The input transfer loads the input register together with the key store
// read, then round logic loads the output register that drives out_valid.
// Throughput: one round per cycle while out_stall is low and no key expansion
// runs, set by the two-port key store read registered with the input.
// While a waiting result is stalled by the receiver, the output register and
// the input stage hold and in_stall is high in that same cycle.
module lightweight_cipher_round import prs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BLOCK_W-1:0]   cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  logic [ROUND_W-1:0]   round_number,
	input  logic                 final_round,
	input  logic [BLOCK_W-1:0]   block_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BLOCK_W-1:0]   block_out
);

	logic               busy;
	logic               adv;
	logic               accept;
	key_rd_req_t        rd_req;
	logic [BLOCK_W-1:0] key_cur;
	logic [BLOCK_W-1:0] key_next;
	logic [BLOCK_W-1:0] round_res;

	logic               valid_s1;
	logic               command_s1;
	logic               final_s1;
	logic [BLOCK_W-1:0] block_s1;
	logic               out_valid_q;
	logic [BLOCK_W-1:0] block_out_q;

	// pipeline moves when the output register is free or being drained
	assign adv = !out_valid_q || !out_stall;
	assign in_stall = busy || !adv;
	assign accept = in_valid && !in_stall;

	// key indexes for this round and the next
	always_comb begin
		rd_req.en = adv;
		rd_req.idx_cur = round_number - ROUND_W'(1);
		rd_req.idx_next = round_number;
	end

	prs_key_sched u_key_sched (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rd_req   (rd_req),
		.busy     (busy),
		.key_cur  (key_cur),
		.key_next (key_next)
	);

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			command_s1 <= command;
			final_s1 <= final_round;
			block_s1 <= block_in;
		end
	end

	prs_round u_round (
		.command    (command_s1),
		.final_round(final_s1),
		.block_in   (block_s1),
		.key_cur    (key_cur),
		.key_next   (key_next),
		.block_out  (round_res)
	);

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			block_out_q <= round_res;
		end
	end

	assign out_valid = out_valid_q;
	assign block_out = block_out_q;

endmodule

// ===== bench/tb_lightweight_cipher_round.sv =====
module tb_lightweight_cipher_round import prs_pkg::*; ();

	// index with no register behind it, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int ITEMS_PER_SETTING = 125;
	localparam int NUM_SETTINGS = 10;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD_CYCLES = 120;

	// sbox tables, nibble n holds the image of n
	localparam logic [63:0] FWD_SBOX = 64'h2174_8fe3_da09_b65c;
	localparam logic [63:0] REV_SBOX = 64'ha970_364b_d21c_8fe5;

	typedef enum logic [1:0] {
		MODE_SLOW_SINK,
		MODE_SLOW_SOURCE,
		MODE_BACK_TO_BACK
	} traffic_mode_t;

	typedef struct packed {
		logic               cmd;
		logic [ROUND_W-1:0] rnd;
		logic               fin;
		logic [BLOCK_W-1:0] blk;
	} round_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BLOCK_W-1:0]   cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 command = CMD_ENCRYPT;
	logic [ROUND_W-1:0]   round_number = '0;
	logic                 final_round = 1'b0;
	logic [BLOCK_W-1:0]   block_in = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [BLOCK_W-1:0]   block_out;

	// predictor state: key registers and expanded schedule
	logic               wide_mode;
	logic [BLOCK_W-1:0] key_hi;
	logic [BLOCK_W-1:0] key_lo;
	logic [BLOCK_W-1:0] round_keys [NUM_ROUND_KEYS];

	round_item_t        pending_rounds [$];
	logic [BLOCK_W-1:0] expected_blocks [$];
	round_item_t        offered;
	traffic_mode_t      traffic_mode = MODE_SLOW_SINK;

	int rounds_sent = 0;
	int results_checked = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	int key_settings = 0;

	lightweight_cipher_round dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.round_number (round_number),
		.final_round  (final_round),
		.block_in     (block_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.block_out    (block_out)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [3:0] sbox_nib(input logic [3:0] n, input logic inv);
		return inv ? REV_SBOX[4*int'(n) +: 4] : FWD_SBOX[4*int'(n) +: 4];
	endfunction

	function automatic logic [BLOCK_W-1:0] sub_nibbles(input logic [BLOCK_W-1:0] d,
		input logic inv);
		logic [BLOCK_W-1:0] r;
		for (int i = 0; i < BLOCK_W / 4; i++) begin
			r[4*i +: 4] = sbox_nib(d[4*i +: 4], inv);
		end
		return r;
	endfunction

	// bit spreading layer and its inverse
	function automatic logic [BLOCK_W-1:0] spread_bits(input logic [BLOCK_W-1:0] d,
		input logic inv);
		logic [BLOCK_W-1:0] r;
		int to;
		for (int i = 0; i < BLOCK_W; i++) begin
			to = inv ? 4 * (i % 16) + i / 16 : 16 * (i % 4) + i / 4;
			r[to] = d[i];
		end
		return r;
	endfunction

	// rebuild the round key schedule from the key registers
	function automatic void expand_round_keys();
		logic [79:0]  k80;
		logic [127:0] k128;
		k80 = {key_hi[15:0], key_lo};
		k128 = {key_hi, key_lo};
		for (int i = 0; i < NUM_ROUND_KEYS; i++) begin
			if (i > 0) begin
				k80 = {k80[18:0], k80[79:19]};
				k80[79:76] = sbox_nib(k80[79:76], 1'b0);
				k80[19:15] = k80[19:15] ^ 5'(i);
				k128 = {k128[66:0], k128[127:67]};
				k128[127:124] = sbox_nib(k128[127:124], 1'b0);
				k128[123:120] = sbox_nib(k128[123:120], 1'b0);
				k128[66:62] = k128[66:62] ^ 5'(i);
			end
			round_keys[i] = wide_mode ? k128[127:64] : k80[79:16];
		end
	endfunction

	// keys past the end of the store read as zero
	function automatic logic [BLOCK_W-1:0] key_at(input logic [ROUND_W-1:0] idx);
		if (int'(idx) >= NUM_ROUND_KEYS) begin
			return '0;
		end
		return round_keys[idx];
	endfunction

	// one cipher round; round zero takes key 31 as its current key
	function automatic logic [BLOCK_W-1:0] predict_round(input round_item_t it);
		logic [BLOCK_W-1:0] d;
		logic [BLOCK_W-1:0] k_cur;
		logic [BLOCK_W-1:0] k_next;
		logic [ROUND_W-1:0] cur_idx;
		cur_idx = it.rnd - ROUND_W'(1);
		k_cur = key_at(cur_idx);
		k_next = key_at(it.rnd);
		d = it.blk;
		if (it.cmd == CMD_ENCRYPT) begin
			d = spread_bits(sub_nibbles(d ^ k_cur, 1'b0), 1'b0);
			if (it.fin) begin
				d = d ^ k_next;
			end
		end else begin
			if (it.fin) begin
				d = d ^ k_next;
			end
			d = sub_nibbles(spread_bits(d, 1'b1), 1'b1) ^ k_cur;
		end
		return d;
	endfunction

	function automatic int source_gap_pct(input traffic_mode_t m);
		case (m)
			MODE_SLOW_SINK:   return 27;
			MODE_SLOW_SOURCE: return 88;
			default:          return 0;
		endcase
	endfunction

	function automatic int sink_hold_pct(input traffic_mode_t m);
		case (m)
			MODE_SLOW_SINK:   return 88;
			MODE_SLOW_SOURCE: return 27;
			default:          return 0;
		endcase
	endfunction

	function automatic round_item_t random_round();
		round_item_t it;
		it.cmd = 1'($urandom_range(1));
		it.rnd = ROUND_W'($urandom_range(31));
		it.fin = 1'($urandom_range(1));
		case ($urandom_range(15))
			0:       it.blk = '0;
			1:       it.blk = '1;
			default: it.blk = {$urandom, $urandom};
		endcase
		return it;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// wait until no transfer is pending or outstanding
	task automatic wait_drained();
		@(negedge clk);
		while (pending_rounds.size() != 0 || in_valid || expected_blocks.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// register write once the block is idle, then mirror it in the predictor
	task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [BLOCK_W-1:0] val);
		bit rebuild;
		rebuild = 1'b1;
		@(negedge clk);
		while (in_stall !== 1'b0) begin
			@(negedge clk);
		end
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WIDE_KEY_MODE: wide_mode = val[0];
			REG_KEY_UPPER:     key_hi = val;
			REG_KEY_LOWER:     key_lo = val;
			default:           rebuild = 1'b0;
		endcase
		if (rebuild) begin
			expand_round_keys();
		end
	endtask

	// input driver: offers queued rounds, predicts each on transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_blocks.insert(expected_blocks.size(), predict_round(offered));
				rounds_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_rounds.size() != 0 &&
					$urandom_range(99) >= source_gap_pct(traffic_mode)) begin
					offered = pending_rounds.pop_front();
					command <= offered.cmd;
					round_number <= offered.rnd;
					final_round <= offered.fin;
					block_in <= offered.blk;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output stall: random, plus one long hold when back-to-back traffic starts
	traffic_mode_t seen_mode = MODE_SLOW_SINK;
	int hold_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (traffic_mode != seen_mode) begin
				seen_mode = traffic_mode;
				if (traffic_mode == MODE_BACK_TO_BACK) begin
					hold_left = LONG_HOLD_CYCLES;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < sink_hold_pct(traffic_mode));
			end
		end
	end

	// monitor: compare each output transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_blocks.size() == 0) begin
				flag_mismatch($sformatf("block_out %h with no round outstanding", block_out));
			end else if (block_out !== expected_blocks[0]) begin
				flag_mismatch($sformatf("block_out %h, predicted %h",
					block_out, expected_blocks[0]));
				void'(expected_blocks.pop_front());
			end else begin
				void'(expected_blocks.pop_front());
			end
			results_checked++;
		end
	end

	// watchdog on cycles without any transfer or register write
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", idle_cycles);
				$display("FAILURE");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// stimulus sequence
	initial begin
		logic [BLOCK_W-1:0] patterns [4];
		logic               mode_sel;
		logic [BLOCK_W-1:0] up_val;
		logic [BLOCK_W-1:0] lo_val;
		int                 n;
		patterns[0] = '0;
		patterns[1] = '1;
		patterns[2] = 64'haaaa_aaaa_aaaa_aaaa;
		patterns[3] = 64'h0123_4567_89ab_cdef;
		n = 0;
		wide_mode = 1'b0;
		key_hi = '0;
		key_lo = '0;
		expand_round_keys();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed rounds on the reset key: both directions, final or not,
		// round zero wrap and the last round
		@(negedge clk);
		for (int c = 0; c < 2; c++) begin
			for (int f = 0; f < 2; f++) begin
				foreach (patterns[p]) begin
					if (p < 3) begin
						pending_rounds.insert(pending_rounds.size(), round_item_t'{
							c ? CMD_DECRYPT : CMD_ENCRYPT,
							(p == 0) ? 5'd0 : (p == 1) ? 5'd1 : 5'd31,
							1'(f), patterns[n % 4]});
						n++;
					end
				end
			end
		end
		for (int i = 0; i < 6; i++) begin
			pending_rounds.insert(pending_rounds.size(), random_round());
		end
		wait_drained();
		key_settings = 1;

		// random rounds over a series of key settings
		for (int s = 0; s < NUM_SETTINGS; s++) begin
			case (s)
				0: begin
					mode_sel = 1'b0;
					up_val = '1;
					lo_val = '1;
				end
				1: begin
					mode_sel = 1'b1;
					up_val = '0;
					lo_val = '0;
				end
				2: begin
					mode_sel = 1'b1;
					up_val = '1;
					lo_val = '1;
				end
				default: begin
					mode_sel = 1'(s % 2);
					up_val = {$urandom, $urandom};
					lo_val = {$urandom, $urandom};
				end
			endcase
			write_key_reg(REG_WIDE_KEY_MODE, {{(BLOCK_W-1){1'b0}}, mode_sel});
			write_key_reg(REG_KEY_UPPER, up_val);
			write_key_reg(REG_KEY_LOWER, lo_val);
			if (s == 3) begin
				write_key_reg(REG_UNUSED, {$urandom, $urandom});
			end
			key_settings++;
			@(negedge clk);
			traffic_mode = (s < 4) ? MODE_SLOW_SINK :
				(s < 7) ? MODE_SLOW_SOURCE : MODE_BACK_TO_BACK;
			for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
				pending_rounds.insert(pending_rounds.size(), random_round());
			end
			wait_drained();
		end

		// let the pipeline settle, then look for anything left behind
		repeat (6) @(negedge clk);
		if (expected_blocks.size() != 0) begin
			flag_mismatch($sformatf("%0d rounds never came out", expected_blocks.size()));
		end
		$display("ran %0d rounds (%0d checked) under %0d key settings, 80 and 128 bit",
			rounds_sent, results_checked, key_settings);
		$display("encrypt and decrypt, final and plain rounds, %0d mismatches", mismatches);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/prs_pkg.sv
rtl/core/prs_key_sched.sv
rtl/core/prs_round.sv
rtl/core/lightweight_cipher_round.sv
bench/tb_lightweight_cipher_round.sv
